>>> hdl/smf_pkg.sv
// smf_pkg: shared types for the sliding median filter
// no dependencies; used by smf_rank and sliding_median_filter_unit
`timescale 1ns / 1ps
`default_nettype none

package smf_pkg;

  // sequencer states, one-hot
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_HOLD = 3'b100
  } state_t;

  // per-step request from the sequencer to the rank unit
  typedef struct packed {
    logic active;
    logic last;
  } step_t;

endpackage

`default_nettype wire

>>> hdl/smf_if.sv
// smf_sample_if, smf_median_if: valid/ready stream channels for samples and medians
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface smf_sample_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface smf_median_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] median;

  modport source (output valid, output median, input ready);
  modport sink   (input valid, input median, output ready);
endinterface

`default_nettype wire

>>> hdl/smf_rank.sv
// smf_rank: stable rank of one window entry against the whole window
// depends on smf_pkg
`timescale 1ns / 1ps
`default_nettype none

module smf_rank #(
  parameter int WINDOW       = 10,
  parameter int SAMPLE_WIDTH = 16,
  localparam int IW = $clog2(WINDOW),
  localparam int CW = $clog2(WINDOW + 1)
) (
  input  wire logic signed [SAMPLE_WIDTH-1:0] win [WINDOW],
  input  wire logic        [IW-1:0]           idx,
  input  wire smf_pkg::step_t                 step,
  output logic                                is_median
);

  localparam int MID = WINDOW / 2;

  logic signed [SAMPLE_WIDTH-1:0] cand;
  logic        [CW-1:0]           rank;

  assign cand = win[idx];

  // entries below the candidate, ties broken by position
  always_comb begin
    rank = '0;
    for (int j = 0; j < WINDOW; j++) begin
      if ((win[j] < cand) || ((win[j] == cand) && (IW'(j) < idx))) begin
        rank = rank + CW'(1);
      end
    end
  end

  assign is_median = step.active && (rank == CW'(MID));

endmodule

`default_nettype wire

>>> hdl/sliding_median_filter_unit.sv
// sliding_median_filter_unit: upper median over a sliding window of samples
// a new sample is accepted only in idle, after the previous median has been
// loaded into the output register; the scan takes one rank step per window
// entry through the shared rank unit
// reset: synchronous active-high rst zeroes the window and empties the output
// depends on smf_pkg, smf_if (smf_sample_if, smf_median_if), smf_rank
`timescale 1ns / 1ps
`default_nettype none

module sliding_median_filter_unit #(
  parameter int WINDOW       = 10,
  parameter int SAMPLE_WIDTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  smf_sample_if.sink       feed,
  smf_median_if.source     result
);

  localparam int IW = $clog2(WINDOW);

  smf_pkg::state_t                state;
  logic signed [SAMPLE_WIDTH-1:0] win [WINDOW];
  logic        [IW-1:0]           idx;
  logic                           found;
  logic signed [SAMPLE_WIDTH-1:0] held;
  logic                           out_valid;
  logic signed [SAMPLE_WIDTH-1:0] out_median;
  smf_pkg::step_t                 step;
  logic                           is_median;
  logic                           in_beat;
  logic                           out_free;

  assign in_beat  = feed.valid && feed.ready;
  assign out_free = !out_valid || result.ready;

  assign feed.ready    = (state == smf_pkg::S_IDLE);
  assign result.valid  = out_valid;
  assign result.median = out_median;

  assign step.active = (state == smf_pkg::S_SCAN);
  assign step.last   = (idx == IW'(WINDOW - 1));

  smf_rank #(
    .WINDOW       (WINDOW),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_rank (
    .win       (win),
    .idx       (idx),
    .step      (step),
    .is_median (is_median)
  );

  // delay line, newest at entry 0
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOW; i++) begin
        win[i] <= '0;
      end
    end else if (in_beat) begin
      win[0] <= feed.sample;
      for (int i = 1; i < WINDOW; i++) begin
        win[i] <= win[i-1];
      end
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= smf_pkg::S_IDLE;
      idx   <= '0;
      found <= 1'b0;
    end else begin
      unique case (state)
        smf_pkg::S_IDLE: begin
          if (in_beat) begin
            state <= smf_pkg::S_SCAN;
            idx   <= '0;
            found <= 1'b0;
          end
        end
        smf_pkg::S_SCAN: begin
          if (is_median) begin
            found <= 1'b1;
          end
          if (step.last) begin
            state <= smf_pkg::S_HOLD;
          end else begin
            idx <= idx + IW'(1);
          end
        end
        smf_pkg::S_HOLD: begin
          if (out_free) begin
            state <= smf_pkg::S_IDLE;
          end
        end
        default: begin
          state <= smf_pkg::S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (is_median) begin
      held <= win[idx];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if ((state == smf_pkg::S_HOLD) && out_free) begin
        out_valid <= 1'b1;
      end else if (result.valid && result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state == smf_pkg::S_HOLD) && out_free) begin
      out_median <= held;
    end
  end

`ifndef SYNTH
  a_beat_starts_scan: assert property (@(posedge clk) disable iff (rst)
    in_beat |=> (state == smf_pkg::S_SCAN) && (idx == '0))
    else $error("sample beat did not start a scan at entry zero");

  a_hold_has_median: assert property (@(posedge clk) disable iff (rst)
    (state == smf_pkg::S_HOLD) |-> found)
    else $error("scan finished without a median");

  a_scan_ends_in_hold: assert property (@(posedge clk) disable iff (rst)
    (step.active && step.last) |=> (state == smf_pkg::S_HOLD))
    else $error("scan overran the window");

  a_out_from_hold: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == smf_pkg::S_HOLD))
    else $error("result beat raised outside hold");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != smf_pkg::S_IDLE) |-> !feed.ready)
    else $error("sample accepted while scanning");
`endif

endmodule

`default_nettype wire
